// File: hw/rtl/tao_pkg.sv
// shared types, constants and helpers for the tint and alpha-over blend block
package tao_pkg;

    // luma weights, w = 54*r + 183*g + 19*b
    localparam int unsigned LUMA_R      = 54;
    localparam int unsigned LUMA_G      = 183;
    localparam int unsigned LUMA_B      = 19;

    localparam int unsigned HAIR_MIN_W  = 6528;
    localparam int unsigned HAIR_K      = 21;
    localparam int unsigned HAIR_BASE   = 7 * 65280;
    localparam int unsigned HAIR_DEN    = 20 * 65280;

    localparam int unsigned SKIN_MIN_W  = 23552;
    localparam int unsigned SKIN_UNIT   = 45568;
    localparam int unsigned CLAMP_LO    = 42;
    localparam int unsigned CLAMP_HI    = 135;
    localparam int unsigned PCT         = 100;

    localparam int unsigned MAX_CHAN    = 255;

    // tint ratio width, tint product width, quotient width, blend numerator width
    localparam int unsigned TN_W        = 21;
    localparam int unsigned TP_W        = 29;
    localparam int unsigned QT_W        = 9;
    localparam int unsigned BN_W        = 17;

    // floor(y/255) = (y * M) >> 33, exact for y below 2^25
    localparam int unsigned DIV255_M    = 33686019;
    localparam int unsigned DIV255_SH   = 33;

    localparam int unsigned FQ_DEPTH    = 4;
    localparam int unsigned FQ_AW       = $clog2(FQ_DEPTH);
    localparam int unsigned OQ_DEPTH    = 32;
    localparam int unsigned OQ_AW       = $clog2(OQ_DEPTH);

    // config register indexes
    localparam logic [7:0] REG_TINT_RED   = 8'd0;
    localparam logic [7:0] REG_TINT_GREEN = 8'd1;
    localparam logic [7:0] REG_TINT_BLUE  = 8'd2;
    localparam logic [7:0] REG_TINT_MODE  = 8'd3;

    // tint modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_HAIR = 2'd1;
    localparam logic [1:0] MODE_SKIN = 2'd2;

    typedef struct packed {
        logic [2:0][7:0] c;
    } t_tint;

    typedef struct packed {
        logic [2:0][7:0] src;
        logic [7:0]      sa;
        logic [2:0][7:0] dst;
        logic [7:0]      da;
        logic            tinted;
    } t_px;

    typedef struct packed {
        t_px             px;
        logic [TN_W-1:0] num;
        logic [TN_W-1:0] den;
    } t_item;

    typedef struct packed {
        logic [2:0][7:0] s;
        logic [2:0][7:0] d;
        logic [7:0]      da;
        logic [7:0]      sa;
        logic [7:0]      oa;
    } t_bl;

    typedef struct packed {
        logic [2:0][7:0] c;
        logic [7:0]      a;
    } t_out;

    // round(x/255) for x up to 255*255
    function automatic logic [7:0] div255_rnd(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] s;
        y = {1'b0, x} + 17'd127;
        s = y + (y >> 8) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: hw/rtl/tao_div.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor across lanes
module tao_div
    import tao_pkg::*;
#(
    parameter int LANES = 3,
    parameter int NUM_W = 29,
    parameter int DEN_W = 21,
    parameter int Q_W   = 9,
    parameter int SB_W  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]               i_den,
    input  logic [SB_W-1:0]                i_sb,
    output logic                           o_valid,
    output logic [LANES-1:0][Q_W-1:0]      o_q,
    output logic [SB_W-1:0]                o_sb
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic                        r_v   [Q_W];
    logic [LANES-1:0][RW-1:0]    r_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_q   [Q_W];
    logic [DEN_W-1:0]            r_den [Q_W];
    logic [SB_W-1:0]             r_sb  [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                      w_v;
        logic [LANES-1:0][RW-1:0]  w_rem;
        logic [LANES-1:0][Q_W-1:0] w_q;
        logic [DEN_W-1:0]          w_den;
        logic [SB_W-1:0]           w_sb;
        logic [RW-1:0]             w_dsh;
        logic [LANES-1:0][RW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_q;

        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = RW'(i_num[l]);
                end
                w_v   = i_valid;
                w_q   = '0;
                w_den = i_den;
                w_sb  = i_sb;
            end
        end else begin : g_next
            assign w_v   = r_v[s-1];
            assign w_rem = r_rem[s-1];
            assign w_q   = r_q[s-1];
            assign w_den = r_den[s-1];
            assign w_sb  = r_sb[s-1];
        end

        assign w_dsh = RW'(w_den) << (Q_W - 1 - s);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (w_rem[l] >= w_dsh) begin
                    n_rem[l] = w_rem[l] - w_dsh;
                    n_q[l]   = w_q[l] | (Q_W'(1) << (Q_W - 1 - s));
                end else begin
                    n_rem[l] = w_rem[l];
                    n_q[l]   = w_q[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= w_v;
            end
            r_rem[s] <= n_rem;
            r_q[s]   <= n_q;
            r_den[s] <= w_den;
            r_sb[s]  <= w_sb;
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_q     = r_q[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

// File: hw/rtl/tao_front.sv
// front end: luma and skin classification, tint ratio select, item queue
module tao_front
    import tao_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_mode,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_src_red,
    input  logic [7:0]  i_src_green,
    input  logic [7:0]  i_src_blue,
    input  logic [7:0]  i_src_alpha,
    input  logic [7:0]  i_dst_red,
    input  logic [7:0]  i_dst_green,
    input  logic [7:0]  i_dst_blue,
    input  logic [7:0]  i_dst_alpha,
    input  logic        i_pop,
    output logic        o_empty,
    output t_item       o_item
);

    logic [15:0]     w_r16, w_g16, w_b16, w_luma;
    logic [22:0]     w_luma100;
    logic [7:0]      w_hi, w_lo, w_rg_hi, w_rg_lo;
    logic [12:0]     w_r13, w_g13, w_b13;
    logic [10:0]     w_spread;
    logic            w_vis, w_skin, w_tinted;
    logic [TN_W-1:0] w_num, w_den;
    t_item           w_item;
    logic            w_wr;

    t_item           r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, r_rp;
    logic [FQ_AW:0]  r_cnt;

    assign w_r16  = {8'd0, i_src_red};
    assign w_g16  = {8'd0, i_src_green};
    assign w_b16  = {8'd0, i_src_blue};
    assign w_luma = w_r16 * 16'(LUMA_R) + w_g16 * 16'(LUMA_G) + w_b16 * 16'(LUMA_B);
    assign w_luma100 = {7'd0, w_luma} * 23'(PCT);

    assign w_rg_hi = (i_src_red > i_src_green) ? i_src_red : i_src_green;
    assign w_rg_lo = (i_src_red < i_src_green) ? i_src_red : i_src_green;
    assign w_hi    = (w_rg_hi > i_src_blue) ? w_rg_hi : i_src_blue;
    assign w_lo    = (w_rg_lo < i_src_blue) ? w_rg_lo : i_src_blue;
    assign w_spread = {3'd0, w_hi - w_lo} * 11'd5;

    assign w_r13 = {5'd0, i_src_red};
    assign w_g13 = {5'd0, i_src_green};
    assign w_b13 = {5'd0, i_src_blue};

    assign w_vis  = (i_src_alpha != 8'd0);
    assign w_skin = (w_luma >= 16'(SKIN_MIN_W)) && (w_spread >= {3'd0, w_hi})
                 && (w_r13 * 13'd25 >= w_g13 * 13'd26)
                 && (w_g13 * 13'd25 >= w_b13 * 13'd23);

    always_comb begin
        w_tinted = 1'b0;
        w_num    = TN_W'(1);
        w_den    = TN_W'(1);
        unique case (i_mode)
            MODE_HAIR: begin
                w_tinted = w_vis && (w_luma >= 16'(HAIR_MIN_W));
                w_num    = TN_W'(HAIR_BASE) + TN_W'(w_luma) * TN_W'(HAIR_K);
                w_den    = TN_W'(HAIR_DEN);
            end
            MODE_SKIN: begin
                w_tinted = w_vis && w_skin;
                if (w_luma100 < 23'(CLAMP_LO * SKIN_UNIT)) begin
                    w_num = TN_W'(CLAMP_LO);
                    w_den = TN_W'(PCT);
                end else if (w_luma100 > 23'(CLAMP_HI * SKIN_UNIT)) begin
                    w_num = TN_W'(CLAMP_HI);
                    w_den = TN_W'(PCT);
                end else begin
                    w_num = TN_W'(w_luma);
                    w_den = TN_W'(SKIN_UNIT);
                end
            end
            default: begin
                w_tinted = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_item.px.src    = {i_src_blue, i_src_green, i_src_red};
        w_item.px.sa     = i_src_alpha;
        w_item.px.dst    = {i_dst_blue, i_dst_green, i_dst_red};
        w_item.px.da     = i_dst_alpha;
        w_item.px.tinted = w_tinted;
        w_item.num       = w_num;
        w_item.den       = w_den;
    end

    assign o_full  = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FQ_AW+1)'(w_wr) - (FQ_AW+1)'(i_pop && !o_empty);
        end
        if (w_wr) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// File: hw/rtl/tao_back.sv
// back end: tint scaling, source-over blend and the result queue
module tao_back
    import tao_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tint       i_tint,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  t_item       i_item,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    localparam int SBT_W = $bits(t_px);
    localparam int SBB_W = $bits(t_bl);

    // credits: items issued and not yet popped from the result queue
    logic [OQ_AW:0]  r_cnt;
    logic            w_issue, w_opop;

    // stage 0: tint products
    logic            r_s0_v;
    t_px             r_s0_px;
    logic [2:0][TP_W-1:0] r_s0_prod;
    logic [TN_W-1:0] r_s0_den;
    logic [2:0][TP_W-1:0] w_t_num;

    logic            w_d1_v;
    logic [2:0][QT_W-1:0] w_d1_q;
    logic [SBT_W-1:0] w_d1_sb;
    t_px             w_d1_px;
    logic [2:0][7:0] w_s;

    // blend stages
    logic            r_b1_v, r_b2_v, r_b3_v;
    logic [2:0][7:0] r_b1_s, r_b2_s, r_b3_s;
    logic [2:0][7:0] r_b1_d, r_b2_d, r_b3_d;
    logic [2:0][15:0] r_b1_sp, r_b2_sp, r_b3_sp;
    logic [7:0]      r_b1_sa, r_b2_sa, r_b3_sa;
    logic [7:0]      r_b1_da, r_b2_da, r_b3_da;
    logic [15:0]     r_b1_pdi;
    logic [7:0]      r_b2_oa, r_b3_oa;
    logic [2:0][23:0] r_b2_dd;
    logic [2:0][15:0] r_b3_dq;
    logic [2:0][50:0] w_mag;

    logic [2:0][BN_W-1:0] w_b_num;
    t_bl             w_bl_in, w_bl_out;
    logic            w_d2_v;
    logic [2:0][QT_W-1:0] w_d2_q;
    logic [SBB_W-1:0] w_d2_sb;
    t_out            w_res;

    t_out            r_of [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp, r_orp;
    logic [OQ_AW:0]  r_ocnt;

    assign w_issue = !i_q_empty && (r_cnt < (OQ_AW+1)'(OQ_DEPTH));
    assign o_q_pop = w_issue;
    assign o_empty = (r_ocnt == '0);
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= w_issue;
        end
        r_s0_px  <= i_item.px;
        r_s0_den <= i_item.den;
        for (int l = 0; l < 3; l++) begin
            r_s0_prod[l] <= {21'd0, i_tint.c[l]} * {8'd0, i_item.num};
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_t_num[l] = r_s0_prod[l] + TP_W'(r_s0_den >> 1);
        end
    end

    tao_div #(
        .LANES (3),
        .NUM_W (TP_W),
        .DEN_W (TN_W),
        .Q_W   (QT_W),
        .SB_W  (SBT_W)
    ) u_tint_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_v),
        .i_num   (w_t_num),
        .i_den   (r_s0_den),
        .i_sb    (r_s0_px),
        .o_valid (w_d1_v),
        .o_q     (w_d1_q),
        .o_sb    (w_d1_sb)
    );

    assign w_d1_px = w_d1_sb;

    // tinted channels saturate at 255
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_d1_px.tinted) begin
                w_s[l] = w_d1_q[l][QT_W-1] ? 8'(MAX_CHAN) : w_d1_q[l][7:0];
            end else begin
                w_s[l] = w_d1_px.src[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = {26'd0, {1'b0, r_b2_dd[l]} + 25'd127} * 51'(DIV255_M);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else begin
            r_b1_v <= w_d1_v;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
        end
        // b1: source terms and inverse alpha product
        r_b1_s   <= w_s;
        r_b1_d   <= w_d1_px.dst;
        r_b1_sa  <= w_d1_px.sa;
        r_b1_da  <= w_d1_px.da;
        r_b1_pdi <= {8'd0, w_d1_px.da} * {8'd0, 8'(MAX_CHAN) - w_d1_px.sa};
        for (int l = 0; l < 3; l++) begin
            r_b1_sp[l] <= {8'd0, w_s[l]} * {8'd0, w_d1_px.sa};
        end
        // b2: output alpha and destination products
        r_b2_s  <= r_b1_s;
        r_b2_d  <= r_b1_d;
        r_b2_sp <= r_b1_sp;
        r_b2_sa <= r_b1_sa;
        r_b2_da <= r_b1_da;
        r_b2_oa <= r_b1_sa + div255_rnd(r_b1_pdi);
        for (int l = 0; l < 3; l++) begin
            r_b2_dd[l] <= {16'd0, r_b1_d[l]} * {8'd0, r_b1_pdi};
        end
        // b3: rounded destination term over 255
        r_b3_s  <= r_b2_s;
        r_b3_d  <= r_b2_d;
        r_b3_sp <= r_b2_sp;
        r_b3_sa <= r_b2_sa;
        r_b3_da <= r_b2_da;
        r_b3_oa <= r_b2_oa;
        for (int l = 0; l < 3; l++) begin
            r_b3_dq[l] <= w_mag[l][DIV255_SH+15:DIV255_SH];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_b_num[l] = BN_W'(r_b3_sp[l]) + BN_W'(r_b3_dq[l]) + BN_W'(r_b3_oa >> 1);
        end
        w_bl_in.s  = r_b3_s;
        w_bl_in.d  = r_b3_d;
        w_bl_in.da = r_b3_da;
        w_bl_in.sa = r_b3_sa;
        w_bl_in.oa = r_b3_oa;
    end

    tao_div #(
        .LANES (3),
        .NUM_W (BN_W),
        .DEN_W (8),
        .Q_W   (QT_W),
        .SB_W  (SBB_W)
    ) u_blend_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b3_v),
        .i_num   (w_b_num),
        .i_den   (r_b3_oa),
        .i_sb    (w_bl_in),
        .o_valid (w_d2_v),
        .o_q     (w_d2_q),
        .o_sb    (w_d2_sb)
    );

    assign w_bl_out = w_d2_sb;

    // transparent source keeps the destination, opaque source copies the source
    always_comb begin
        if (w_bl_out.sa == 8'd0) begin
            w_res.c = w_bl_out.d;
            w_res.a = w_bl_out.da;
        end else if (w_bl_out.sa == 8'(MAX_CHAN)) begin
            w_res.c = w_bl_out.s;
            w_res.a = 8'(MAX_CHAN);
        end else begin
            for (int l = 0; l < 3; l++) begin
                w_res.c[l] = w_d2_q[l][QT_W-1] ? 8'(MAX_CHAN) : w_d2_q[l][7:0];
            end
            w_res.a = w_bl_out.oa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ocnt <= '0;
            r_owp  <= '0;
            r_orp  <= '0;
        end else begin
            r_cnt  <= r_cnt + (OQ_AW+1)'(w_issue) - (OQ_AW+1)'(w_opop);
            r_ocnt <= r_ocnt + (OQ_AW+1)'(w_d2_v) - (OQ_AW+1)'(w_opop);
            if (w_d2_v) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_opop) begin
                r_orp <= r_orp + 1'b1;
            end
        end
        if (w_d2_v) begin
            r_of[r_owp] <= w_res;
        end
    end

    assign o_out_red   = r_of[r_orp].c[0];
    assign o_out_green = r_of[r_orp].c[1];
    assign o_out_blue  = r_of[r_orp].c[2];
    assign o_out_alpha = r_of[r_orp].a;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("credit count above result queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d2_v |-> (r_ocnt < (OQ_AW+1)'(OQ_DEPTH)))
        else $error("result written into a full queue");

    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= r_cnt)
        else $error("result queue holds more items than issued");

    a_issue_reaches_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_s0_v)
        else $error("issued item lost before tint stage");

endmodule

// File: hw/rtl/tint_and_alpha_over_blend_top.sv
// top level: config registers, front classifier and back blend pipeline
//
// Takes one source RGBA pixel with the destination pixel under it and returns the
// blended destination pixel, after an optional hair or skin tint of the source.
// One item is accepted per cycle sustained while results are popped; a pushed item
// passes the front queue, a tint product stage, two nine-stage divider pipelines
// (tint scale and blend normalization) with three blend stages between them, and
// the result queue write before it shows on the result ports.
// Up to 36 items may be accepted with no result read before push sees full: 32 held
// by the result queue credits plus 4 in the queue that parts the classifier from the
// blend pipeline. Config writes take effect at once and are meant for when the block
// is idle.
module tint_and_alpha_over_blend_top
    import tao_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_src_red,
    input  logic [7:0]  i_src_green,
    input  logic [7:0]  i_src_blue,
    input  logic [7:0]  i_src_alpha,
    input  logic [7:0]  i_dst_red,
    input  logic [7:0]  i_dst_green,
    input  logic [7:0]  i_dst_blue,
    input  logic [7:0]  i_dst_alpha,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    logic [7:0] r_tint_red, r_tint_green, r_tint_blue;
    logic [1:0] r_tint_mode;
    t_tint      w_tint;
    t_item      w_item;
    logic       w_q_empty, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red   <= '0;
            r_tint_green <= '0;
            r_tint_blue  <= '0;
            r_tint_mode  <= MODE_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TINT_RED:   r_tint_red   <= i_cfg_data;
                REG_TINT_GREEN: r_tint_green <= i_cfg_data;
                REG_TINT_BLUE:  r_tint_blue  <= i_cfg_data;
                REG_TINT_MODE:  r_tint_mode  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_tint.c = {r_tint_blue, r_tint_green, r_tint_red};

    tao_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_tint_mode),
        .i_push      (push),
        .o_full      (full),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_src_alpha (i_src_alpha),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .i_dst_alpha (i_dst_alpha),
        .i_pop       (w_q_pop),
        .o_empty     (w_q_empty),
        .o_item      (w_item)
    );

    tao_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tint      (w_tint),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_item      (w_item),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

endmodule

// File: sim/tint_and_alpha_over_blend_top_tb.sv
// testbench for the tint and alpha-over blend block: random and directed pixels checked against a predictor
`timescale 1ns / 1ps

module tint_and_alpha_over_blend_top_tb;
    import tao_pkg::*;

    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT = 40;

    typedef struct {
        logic [7:0] sr, sg, sb, sa;
        logic [7:0] dr, dg, db, da;
    } t_pix;

    typedef struct {
        logic [7:0] r, g, b, a;
    } t_rgba;

    class t_blend_scoreboard;
        logic [7:0] tint_r, tint_g, tint_b;
        logic [1:0] mode;
        t_rgba      expected_px[$];
        int         errors;

        function new();
            tint_r = '0;
            tint_g = '0;
            tint_b = '0;
            mode   = MODE_NONE;
            errors = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [7:0] data);
            case (idx)
                REG_TINT_RED:   tint_r = data;
                REG_TINT_GREEN: tint_g = data;
                REG_TINT_BLUE:  tint_b = data;
                REG_TINT_MODE:  mode = data[1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned rdiv(longint unsigned x, longint unsigned d);
            return (x + d / 2) / d;
        endfunction

        function longint unsigned sat(longint unsigned v);
            return (v > MAX_CHAN) ? MAX_CHAN : v;
        endfunction

        // tint stage then source-over blend
        function t_rgba blend_pixel(t_pix p);
            longint unsigned r, g, b, w, num, den, hi, lo;
            longint unsigned sa, da, inv, oa;
            longint unsigned s[3], d[3];
            bit              tint_on;
            t_rgba           o;
            r = p.sr;
            g = p.sg;
            b = p.sb;
            tint_on = 0;
            num = 0;
            den = 1;
            if (p.sa != 0) begin
                w = LUMA_R * r + LUMA_G * g + LUMA_B * b;
                if (mode == MODE_HAIR) begin
                    if (w >= HAIR_MIN_W) begin
                        tint_on = 1;
                        num = HAIR_BASE + HAIR_K * w;
                        den = HAIR_DEN;
                    end
                end else if (mode == MODE_SKIN) begin
                    hi = (r > g) ? r : g;
                    hi = (hi > b) ? hi : b;
                    lo = (r < g) ? r : g;
                    lo = (lo < b) ? lo : b;
                    if (!(w < SKIN_MIN_W || 5 * (hi - lo) < hi ||
                          25 * r < 26 * g || 25 * g < 23 * b)) begin
                        tint_on = 1;
                        num = w;
                        den = SKIN_UNIT;
                        if (PCT * w < CLAMP_LO * SKIN_UNIT) begin
                            num = CLAMP_LO;
                            den = PCT;
                        end else if (PCT * w > CLAMP_HI * SKIN_UNIT) begin
                            num = CLAMP_HI;
                            den = PCT;
                        end
                    end
                end
            end
            if (tint_on) begin
                r = sat(rdiv(tint_r * num, den));
                g = sat(rdiv(tint_g * num, den));
                b = sat(rdiv(tint_b * num, den));
            end
            sa = p.sa;
            if (sa == 0) begin
                o = '{p.dr, p.dg, p.db, p.da};
            end else if (sa == MAX_CHAN) begin
                o = '{r[7:0], g[7:0], b[7:0], 8'd255};
            end else begin
                s = '{r, g, b};
                d = '{p.dr, p.dg, p.db};
                da = p.da;
                inv = MAX_CHAN - sa;
                oa = sa + rdiv(da * inv, MAX_CHAN);
                for (int c = 0; c < 3; c++)
                    s[c] = sat(rdiv(s[c] * sa + rdiv(d[c] * da * inv, MAX_CHAN), oa));
                o = '{s[0][7:0], s[1][7:0], s[2][7:0], oa[7:0]};
            end
            return o;
        endfunction

        function void note_pixel(t_pix p);
            expected_px.push_back(blend_pixel(p));
        endfunction

        function void check_pixel(t_rgba got);
            t_rgba want;
            if (expected_px.size() == 0) begin
                $error("result with no pixel pending");
                errors++;
                return;
            end
            want = expected_px.pop_front();
            if (got.r !== want.r) begin
                $error("out_red expected %0d actual %0d", want.r, got.r);
                errors++;
            end
            if (got.g !== want.g) begin
                $error("out_green expected %0d actual %0d", want.g, got.g);
                errors++;
            end
            if (got.b !== want.b) begin
                $error("out_blue expected %0d actual %0d", want.b, got.b);
                errors++;
            end
            if (got.a !== want.a) begin
                $error("out_alpha expected %0d actual %0d", want.a, got.a);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       push;
    logic       full;
    logic [7:0] i_src_red, i_src_green, i_src_blue, i_src_alpha;
    logic [7:0] i_dst_red, i_dst_green, i_dst_blue, i_dst_alpha;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_red, o_out_green, o_out_blue, o_out_alpha;

    t_blend_scoreboard sb;
    bit                no_gaps;
    int unsigned       idle_cycles;

    tint_and_alpha_over_blend_top DUT (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(t_pix p);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_src_red   <= p.sr;
        i_src_green <= p.sg;
        i_src_blue  <= p.sb;
        i_src_alpha <= p.sa;
        i_dst_red   <= p.dr;
        i_dst_green <= p.dg;
        i_dst_blue  <= p.db;
        i_dst_alpha <= p.da;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_pixel(p);
    endtask

    // wait for every pending pixel, then let the pipeline settle
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_pix rand_pixel();
        t_pix        p;
        int unsigned k;
        p.sr = 8'($urandom);
        p.sg = 8'($urandom);
        p.sb = 8'($urandom);
        p.dr = 8'($urandom);
        p.dg = 8'($urandom);
        p.db = 8'($urandom);
        p.da = 8'($urandom);
        k = $urandom_range(0, 99);
        // skin-like colors so the skin tests pass often
        if (k < 40) begin
            p.sr = 8'($urandom_range(100, 255));
            p.sg = 8'(p.sr * $urandom_range(60, 97) / 100);
            p.sb = 8'(p.sg * $urandom_range(40, 100) / 100);
        end
        k = $urandom_range(0, 99);
        if (k < 15) p.sa = 8'd0;
        else if (k < 35) p.sa = 8'd255;
        else p.sa = 8'($urandom);
        return p;
    endfunction

    task automatic run_phase(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                             logic [7:0] md, int unsigned n_rand, bit directed);
        t_pix p;
        write_reg(REG_TINT_RED, tr);
        write_reg(REG_TINT_GREEN, tg);
        write_reg(REG_TINT_BLUE, tb);
        write_reg(REG_TINT_MODE, md);
        if (directed) begin
            send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
            send_pixel('{8'd200, 8'd150, 8'd120, 8'd0, 8'd17, 8'd99, 8'd240, 8'd128});
            send_pixel('{8'd220, 8'd170, 8'd140, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255});
            send_pixel('{8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd0, 8'd255, 8'd0});
            send_pixel('{8'd30, 8'd10, 8'd5, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255});
        end
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (n_rand) begin
            p = rand_pixel();
            send_pixel(p);
            if ($urandom_range(0, 199) == 0) no_gaps = ~no_gaps;
        end
        no_gaps = 0;
        drain();
    endtask

    // result side: random stalls, check each accepted pixel
    initial begin
        int unsigned stall;
        pop = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_pixel('{o_out_red, o_out_green, o_out_blue, o_out_alpha});
                stall = pick_gap();
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= i_rst_n;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        no_gaps = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= 8'd0;
        i_cfg_data <= 8'd0;
        push       <= 1'b0;
        i_src_red <= 8'd0; i_src_green <= 8'd0; i_src_blue <= 8'd0; i_src_alpha <= 8'd0;
        i_dst_red <= 8'd0; i_dst_green <= 8'd0; i_dst_blue <= 8'd0; i_dst_alpha <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown register indexes must be ignored
        write_reg(8'd4, 8'hFF);
        write_reg(8'd255, 8'hA5);
        run_phase(8'd0, 8'd0, 8'd0, {6'd0, MODE_NONE}, 200, 1);
        run_phase(8'd255, 8'd255, 8'd255, {6'd0, MODE_HAIR}, 250, 1);
        // upper bits of the mode write are dropped, this lands on skin
        run_phase(8'd255, 8'd255, 8'd255, 8'hFE, 250, 1);
        run_phase(8'd0, 8'd0, 8'd0, {6'd0, MODE_SKIN}, 150, 0);
        run_phase(8'd255, 8'd0, 8'd128, 8'd3, 150, 1);
        run_phase(8'd0, 8'd0, 8'd0, {6'd0, MODE_HAIR}, 100, 1);
        for (int i = 0; i < 4; i++)
            run_phase(8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(1, 2)), 100, 0);

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tao_pkg.sv
hw/rtl/tao_div.sv
hw/rtl/tao_front.sv
hw/rtl/tao_back.sv
hw/rtl/tint_and_alpha_over_blend_top.sv
sim/tint_and_alpha_over_blend_top_tb.sv
